### hw/rtl/bbd_pkg.sv
// Shared types and constants for the bilinear Bayer demosaic block.
// Used by bilinear_bayer_demosaic_top; depends on nothing else.
`default_nettype none

package bbd_pkg;

  // Request function codes.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam int CFG_BITS    = 14;
  localparam int WIDTH_BITS  = 13;
  localparam int HEIGHT_BITS = 14;
  localparam int PORT_BITS   = 16;

  // Sums of up to four samples of at most 16 bits.
  localparam int SUM_BITS = 18;
  // floor(s / 3) == (s * DIV3_MUL) >> DIV3_SHIFT for every s below 2**18.
  localparam logic [SUM_BITS-1:0] DIV3_MUL = 18'd174763;
  localparam int DIV3_SHIFT = 19;

  typedef struct packed {
    logic top;
    logic bot;
    logic lft;
    logic rgt;
    logic even_row;
    logic even_col;
  } pix_flags_t;

  function automatic logic [SUM_BITS-1:0] div3(input logic [SUM_BITS-1:0] s);
    logic [2*SUM_BITS:0] prod;
    prod = s * DIV3_MUL;
    return prod[DIV3_SHIFT +: SUM_BITS];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bilinear_bayer_demosaic_top.sv
// Streaming bilinear demosaic for an RGGB mosaic: two line memories, a 3x3 window
// and a small result queue. Depends on bbd_pkg.
//
//   channel  | handshake                | payload
//   raw      | raw_valid / raw_ready    | func, sample
//   pix      | pix_valid / pix_ready    | red, green, blue, frame_end
//   cfg      | cfg_we (write only)      | cfg_index, cfg_data
//
// One request is taken per cycle while raw_ready is high. A request reads both line memories at its column
// in the cycle it is accepted; the next cycle shifts the window, writes the line
// memories back and computes the pixel, which enters a four-entry result queue.
// A pixel is pushed into the result queue from the second stage and appears on pix from the queue head.
// raw_ready drops only when the queue plus the pixel in flight would fill it.
// Reset clears position, drain state, window and result queue; line memory contents are kept.
`default_nettype none

module bilinear_bayer_demosaic_top #(
  parameter int MAX_LINE_WIDTH = 4096,
  parameter int SAMPLE_BITS    = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         raw_valid,
  output logic                              raw_ready,
  input  wire logic                         func,
  input  wire logic [bbd_pkg::PORT_BITS-1:0] sample,
  output logic                              pix_valid,
  input  wire logic                         pix_ready,
  output logic      [bbd_pkg::PORT_BITS-1:0] red,
  output logic      [bbd_pkg::PORT_BITS-1:0] green,
  output logic      [bbd_pkg::PORT_BITS-1:0] blue,
  output logic                              frame_end,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [bbd_pkg::CFG_BITS-1:0] cfg_data
);
  import bbd_pkg::*;

  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam int WW = $clog2(MAX_LINE_WIDTH + 2);
  localparam int SW = SAMPLE_BITS;
  localparam int QD = 4;

  localparam logic [1:0] AVG_COPY  = 2'd0;
  localparam logic [1:0] AVG_TWO   = 2'd1;
  localparam logic [1:0] AVG_THREE = 2'd2;
  localparam logic [1:0] AVG_FOUR  = 2'd3;

  typedef struct packed {
    logic [PORT_BITS-1:0] red;
    logic [PORT_BITS-1:0] green;
    logic [PORT_BITS-1:0] blue;
    logic                 frame_end;
  } pix_t;

  function automatic logic [WW-1:0] eff_width(input logic [WIDTH_BITS-1:0] fw);
    logic [31:0] e;
    e = 32'({fw[WIDTH_BITS-1:1], 1'b0});
    if (e < 32'd4) begin
      e = 32'd4;
    end else if (e > 32'(MAX_LINE_WIDTH)) begin
      e = 32'(MAX_LINE_WIDTH) & ~32'd1;
    end
    return WW'(e);
  endfunction

  function automatic logic [HEIGHT_BITS-1:0] eff_height(input logic [HEIGHT_BITS-1:0] fh);
    logic [HEIGHT_BITS-1:0] h;
    h = {fh[HEIGHT_BITS-1:1], 1'b0};
    if (h < HEIGHT_BITS'(4)) begin
      h = HEIGHT_BITS'(4);
    end
    return h;
  endfunction

  // Geometry and position.
  logic [WW-1:0]          wd;
  logic [HEIGHT_BITS-1:0] ht;
  logic [AW-1:0]          col;
  logic [HEIGHT_BITS-1:0] row;
  logic                   draining;
  logic [WW-1:0]          vx;

  // Line memories.
  logic [SW-1:0] upper_mem [MAX_LINE_WIDTH];
  logic [SW-1:0] middle_mem [MAX_LINE_WIDTH];
  logic [SW-1:0] rd_upper;
  logic [SW-1:0] rd_middle;

  // Window, row-major: index 0 is upper-left.
  logic [SW-1:0] win [9];
  logic [SW-1:0] win_z [9];
  logic [SW-1:0] win_base [9];
  logic [SW-1:0] win_sh [9];
  logic [SW-1:0] win_e [9];

  // Second stage.
  logic          s1_v;
  logic          s1_emit;
  logic          s1_zfirst;
  logic          s1_flast;
  logic          s1_write;
  logic [AW-1:0] s1_addr;
  logic [SW-1:0] s1_bot;
  pix_flags_t    s1_flags;

  // Result queue.
  pix_t              res_q [QD];
  logic [1:0]        q_head;
  logic [1:0]        q_tail;
  logic [2:0]        q_cnt;
  logic              q_push;
  logic              q_pop;
  pix_t              pix_new;

  // First stage decode.
  logic          take;
  logic          smp_ok;
  logic          fl_ok;
  logic          act;
  logic          emit0;
  logic          flast0;
  logic          zfirst0;
  logic          col_zero;
  logic          col_last;
  logic          vx_zero;
  logic [AW-1:0] rd_addr;
  pix_flags_t    flags0;

  assign raw_ready = (q_cnt + 3'(s1_v & s1_emit)) < 3'(QD);
  assign take      = raw_valid & raw_ready;
  assign smp_ok    = (func == FUNC_SAMPLE) & ~draining;
  assign fl_ok     = (func == FUNC_FLUSH) & draining;
  assign act       = take & (smp_ok | fl_ok);
  assign col_zero  = (col == '0);
  assign col_last  = (WW'(col) == wd - WW'(1));
  assign vx_zero   = (vx == '0);
  assign flast0    = fl_ok & (vx == wd);
  assign zfirst0   = (smp_ok & col_zero) | (fl_ok & vx_zero) | flast0;
  assign emit0     = fl_ok | (smp_ok & (col_zero ? (row >= HEIGHT_BITS'(2)) : (row != '0)));
  assign rd_addr   = smp_ok ? col : (flast0 ? '0 : vx[AW-1:0]);

  always_comb begin
    flags0 = '0;
    if (smp_ok) begin
      if (col_zero) begin
        flags0.top      = (row == HEIGHT_BITS'(2));
        flags0.rgt      = 1'b1;
        flags0.even_row = ~row[0];
        flags0.even_col = 1'b0;
      end else begin
        flags0.top      = (row == HEIGHT_BITS'(1));
        flags0.lft      = (col == AW'(1));
        flags0.even_row = row[0];
        flags0.even_col = col[0];
      end
    end else if (vx_zero) begin
      flags0.rgt      = 1'b1;
      flags0.even_row = 1'b1;
    end else begin
      flags0.bot      = 1'b1;
      flags0.lft      = (vx == WW'(1));
      flags0.rgt      = flast0;
      flags0.even_col = flast0 ? 1'b0 : vx[0];
    end
  end

  // Configuration and raster position.
  always_ff @(posedge clk) begin
    if (rst) begin
      wd       <= eff_width(WIDTH_BITS'(4096));
      ht       <= eff_height(HEIGHT_BITS'(16383));
      col      <= '0;
      row      <= '0;
      draining <= 1'b0;
      vx       <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) begin
        wd <= eff_width(cfg_data[WIDTH_BITS-1:0]);
      end else begin
        ht <= eff_height(cfg_data[HEIGHT_BITS-1:0]);
      end
      col      <= '0;
      row      <= '0;
      draining <= 1'b0;
      vx       <= '0;
    end else if (act) begin
      if (smp_ok) begin
        if (col_last) begin
          col <= '0;
          if (row == ht - HEIGHT_BITS'(1)) begin
            row      <= '0;
            draining <= 1'b1;
            vx       <= '0;
          end else begin
            row <= row + HEIGHT_BITS'(1);
          end
        end else begin
          col <= col + AW'(1);
        end
      end else if (flast0) begin
        draining <= 1'b0;
        vx       <= '0;
      end else begin
        vx <= vx + WW'(1);
      end
    end
  end

  // Line memories: read on accept, write back in the next cycle. A write-back
  // never addresses the column that the next request reads, so the two never collide.
  always_ff @(posedge clk) begin
    if (act) begin
      rd_upper  <= upper_mem[rd_addr];
      rd_middle <= middle_mem[rd_addr];
    end
    if (s1_v && s1_write) begin
      upper_mem[s1_addr]  <= rd_middle;
      middle_mem[s1_addr] <= s1_bot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= act;
    end
    if (act) begin
      s1_emit   <= emit0;
      s1_zfirst <= zfirst0;
      s1_flast  <= flast0;
      s1_write  <= smp_ok;
      s1_addr   <= rd_addr;
      s1_bot    <= smp_ok ? sample[SW-1:0] : '0;
      s1_flags  <= flags0;
    end
  end

  // Window shifting.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_z[r*3]     = win[r*3+1];
      win_z[r*3+1]   = win[r*3+2];
      win_z[r*3+2]   = '0;
    end
    for (int k = 0; k < 9; k++) begin
      win_base[k] = s1_zfirst ? win_z[k] : win[k];
    end
    for (int r = 0; r < 3; r++) begin
      win_sh[r*3]   = win_base[r*3+1];
      win_sh[r*3+1] = win_base[r*3+2];
    end
    win_sh[2] = rd_upper;
    win_sh[5] = rd_middle;
    win_sh[8] = s1_bot;
    for (int k = 0; k < 9; k++) begin
      win_e[k] = s1_zfirst ? win_z[k] : win_sh[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (s1_v) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= s1_flast ? win_z[k] : win_sh[k];
      end
    end
  end

  // Pixel interpolation from the emit window.
  logic [SUM_BITS-1:0] e_nw, e_n, e_ne, e_we, e_c, e_ea, e_sw, e_s, e_se;
  logic [SUM_BITS-1:0] r_val, g_val, b_val, g_sum;
  logic [1:0]          g_mode;

  always_comb begin
    e_nw = SUM_BITS'(win_e[0]);
    e_n  = SUM_BITS'(win_e[1]);
    e_ne = SUM_BITS'(win_e[2]);
    e_we = SUM_BITS'(win_e[3]);
    e_c  = SUM_BITS'(win_e[4]);
    e_ea = SUM_BITS'(win_e[5]);
    e_sw = SUM_BITS'(win_e[6]);
    e_s  = SUM_BITS'(win_e[7]);
    e_se = SUM_BITS'(win_e[8]);
    r_val  = e_c;
    b_val  = e_c;
    g_sum  = e_c;
    g_mode = AVG_COPY;
    if (s1_flags.even_row && s1_flags.even_col) begin
      r_val = e_c;
      if (s1_flags.top && s1_flags.lft) begin
        g_sum = e_s + e_ea;  g_mode = AVG_TWO;
        b_val = e_se;
      end else if (s1_flags.top) begin
        g_sum = e_we + e_ea + e_s;  g_mode = AVG_THREE;
        b_val = (e_sw + e_se) >> 1;
      end else if (s1_flags.lft) begin
        g_sum = e_n + e_s + e_ea;  g_mode = AVG_THREE;
        b_val = (e_ne + e_se) >> 1;
      end else begin
        g_sum = e_we + e_ea + e_n + e_s;  g_mode = AVG_FOUR;
        b_val = (e_nw + e_ne + e_sw + e_se) >> 2;
      end
    end else if (s1_flags.even_row) begin
      r_val = s1_flags.rgt ? e_we : ((e_we + e_ea) >> 1);
      b_val = s1_flags.top ? e_s : ((e_n + e_s) >> 1);
    end else if (s1_flags.even_col) begin
      r_val = s1_flags.bot ? e_n : ((e_n + e_s) >> 1);
      b_val = s1_flags.lft ? e_ea : ((e_we + e_ea) >> 1);
    end else begin
      b_val = e_c;
      if (s1_flags.bot && s1_flags.rgt) begin
        g_sum = e_n + e_we;  g_mode = AVG_TWO;
        r_val = e_nw;
      end else if (s1_flags.bot) begin
        g_sum = e_n + e_we + e_ea;  g_mode = AVG_THREE;
        r_val = (e_nw + e_ne) >> 1;
      end else if (s1_flags.rgt) begin
        g_sum = e_n + e_s + e_we;  g_mode = AVG_THREE;
        r_val = (e_nw + e_sw) >> 1;
      end else begin
        g_sum = e_n + e_s + e_we + e_ea;  g_mode = AVG_FOUR;
        r_val = (e_nw + e_ne + e_sw + e_se) >> 2;
      end
    end
    case (g_mode)
      AVG_TWO:   g_val = g_sum >> 1;
      AVG_THREE: g_val = div3(g_sum);
      AVG_FOUR:  g_val = g_sum >> 2;
      default:   g_val = g_sum;
    endcase
    pix_new.red       = PORT_BITS'(r_val[SW-1:0]);
    pix_new.green     = PORT_BITS'(g_val[SW-1:0]);
    pix_new.blue      = PORT_BITS'(b_val[SW-1:0]);
    pix_new.frame_end = s1_flags.bot & s1_flags.rgt;
  end

  // Result queue.
  assign q_push    = s1_v & s1_emit;
  assign q_pop     = pix_valid & pix_ready;
  assign pix_valid = (q_cnt != '0);
  assign red       = res_q[q_head].red;
  assign green     = res_q[q_head].green;
  assign blue      = res_q[q_head].blue;
  assign frame_end = res_q[q_head].frame_end;

  always_ff @(posedge clk) begin
    if (q_push) begin
      res_q[q_tail] <= pix_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head <= '0;
      q_tail <= '0;
      q_cnt  <= '0;
    end else begin
      if (q_push) begin
        q_tail <= q_tail + 2'd1;
      end
      if (q_pop) begin
        q_head <= q_head + 2'd1;
      end
      q_cnt <= q_cnt + 3'(q_push) - 3'(q_pop);
    end
  end

  // A write-back and a new read never address the same column.
  assert property (@(posedge clk) disable iff (rst)
    (s1_v && s1_write && act) |-> (s1_addr != rd_addr))
    else $error("line memory read/write collision");

  // The queue never overflows.
  assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |-> (q_cnt < 3'(QD)))
    else $error("result queue overflow");

  // While draining, the sample position rests at the frame origin.
  assert property (@(posedge clk) disable iff (rst)
    draining |-> (col == '0 && row == '0))
    else $error("raster position moved during drain");

  // A frame-end pixel comes only from a flush request.
  assert property (@(posedge clk) disable iff (rst)
    (q_push && pix_new.frame_end) |-> !s1_write)
    else $error("frame end from a sample request");

endmodule

`default_nettype wire
